>>> hdl/go_to_goal_steering_defines.svh
// assertion macros for the go-to-goal steering block
`ifndef GO_TO_GOAL_STEERING_DEFINES_SVH
`define GO_TO_GOAL_STEERING_DEFINES_SVH
`ifndef SYNTHESIS
// checked only while out of reset
`define GTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define GTG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GTG_ASSERT(lbl, prop, msg)
`define GTG_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hdl/gtg_pkg.sv
// shared types, constants and the arctangent table of the go-to-goal steering block
package gtg_pkg;

  localparam int DW        = 18;  // goal offset width, signed
  localparam int GUARD     = 8;   // guard bits below the Q5.10 lsb
  localparam int XW        = 28;  // cordic x/y width, signed
  localparam int ZW        = 28;  // cordic angle width, signed, 2^-24 rad
  localparam int KW        = 30;  // gain compensation constant width
  localparam int PW        = XW - 1 + KW;  // speed product width
  localparam int SW        = 17;  // forward speed width
  localparam int TW        = 16;  // turn rate width
  localparam int ROUND_SHIFT = 30 + GUARD;
  localparam int ZSHIFT    = 11;  // 2^-24 rad to Q3.13
  localparam int EW        = 18;  // turn error width before wrap

  localparam int MAX_STEPS        = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [ZW-1:0] PI_Z       = 28'sd52707179;
  localparam logic [KW-1:0]        INV_K_Q30  = 30'd652032874;
  localparam logic signed [EW-1:0] PI_Q13     = 18'sd25736;
  localparam logic signed [EW-1:0] TWO_PI_Q13 = 18'sd51472;
  localparam logic [SW-1:0]        SPEED_MAX  = 17'd131071;
  localparam logic signed [ZW-1:0] Z_ROUND    = 28'sd1024;

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y = 8'd1;

  localparam logic signed [15:0] GOAL_X_RST = 16'sd10240;
  localparam logic signed [15:0] GOAL_Y_RST = 16'sd10240;

  // atan(2^-i) in units of 2^-24 rad
  localparam logic signed [ZW-1:0] ATAN_TAB [0:MAX_STEPS-1] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  // one beat moving down the cell row
  typedef struct packed {
    logic                   zero;     // pose sits on the goal
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
    logic signed [TW-1:0]   heading;
  } cord_t;

endpackage

>>> hdl/gtg_cordic_cell.sv
// one vectoring iteration of the cordic row, with its own pipeline register
module gtg_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gtg_pkg::cord_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gtg_pkg::cord_t out_data
);

  logic           valid_r;
  gtg_pkg::cord_t data_r;
  gtg_pkg::cord_t data_nxt;
  logic signed [gtg_pkg::XW-1:0] xs;
  logic signed [gtg_pkg::XW-1:0] ys;

  assign xs = in_data.x >>> SHIFT;
  assign ys = in_data.y >>> SHIFT;

  always_comb begin
    data_nxt = in_data;
    if (in_data.y[gtg_pkg::XW-1]) begin
      data_nxt.x = in_data.x - ys;
      data_nxt.y = in_data.y + xs;
      data_nxt.z = in_data.z - gtg_pkg::ATAN_TAB[SHIFT];
    end else begin
      data_nxt.x = in_data.x + ys;
      data_nxt.y = in_data.y - xs;
      data_nxt.z = in_data.z + gtg_pkg::ATAN_TAB[SHIFT];
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/gtg_post.sv
// gain compensation, bearing rounding and heading wrap; the last stage is the output register
module gtg_post (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gtg_pkg::cord_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gtg_pkg::SW-1:0]      speed,
  output logic signed [gtg_pkg::TW-1:0] turn
);

  localparam int BW = gtg_pkg::ZW - gtg_pkg::ZSHIFT;
  localparam int QW = gtg_pkg::PW + 1 - gtg_pkg::ROUND_SHIFT;

  // stage 1: multiply and bearing
  logic                              v1_r;
  logic [gtg_pkg::PW-1:0]            prod_r;
  logic [gtg_pkg::PW-1:0]            prod_nxt;
  logic signed [gtg_pkg::TW-1:0]     bear_r;
  logic signed [gtg_pkg::TW-1:0]     bear_nxt;
  logic signed [gtg_pkg::TW-1:0]     head_r;
  logic signed [gtg_pkg::ZW-1:0]     zr;
  logic signed [BW-1:0]              braw;
  logic [gtg_pkg::XW-2:0]            xpos;

  // stage 2: output register
  logic                              v2_r;
  logic [gtg_pkg::SW-1:0]            speed_r;
  logic [gtg_pkg::SW-1:0]            speed_nxt;
  logic signed [gtg_pkg::TW-1:0]     turn_r;
  logic signed [gtg_pkg::TW-1:0]     turn_nxt;
  logic [gtg_pkg::PW:0]              rsum;
  logic [QW-1:0]                     q;
  logic signed [gtg_pkg::EW-1:0]     err;

  logic rdy1;
  logic rdy2;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    xpos = in_data.x[gtg_pkg::XW-1] ? '0 : in_data.x[gtg_pkg::XW-2:0];
    prod_nxt = gtg_pkg::PW'(xpos) * gtg_pkg::PW'(gtg_pkg::INV_K_Q30);
    zr   = in_data.z + gtg_pkg::Z_ROUND;
    braw = BW'(zr >>> gtg_pkg::ZSHIFT);
    if (braw > BW'(gtg_pkg::PI_Q13)) begin
      bear_nxt = gtg_pkg::TW'(gtg_pkg::PI_Q13);
    end else if (braw < -BW'(gtg_pkg::PI_Q13)) begin
      bear_nxt = -gtg_pkg::TW'(gtg_pkg::PI_Q13);
    end else begin
      bear_nxt = gtg_pkg::TW'(braw);
    end
    if (in_data.zero) begin
      prod_nxt = '0;
      bear_nxt = '0;
    end
  end

  always_comb begin
    rsum = {1'b0, prod_r} + ((gtg_pkg::PW + 1)'(1) << (gtg_pkg::ROUND_SHIFT - 1));
    q    = rsum[gtg_pkg::PW:gtg_pkg::ROUND_SHIFT];
    if (q > QW'(gtg_pkg::SPEED_MAX)) begin
      speed_nxt = gtg_pkg::SPEED_MAX;
    end else begin
      speed_nxt = q[gtg_pkg::SW-1:0];
    end
    err = gtg_pkg::EW'(bear_r) - gtg_pkg::EW'(head_r);
    if (err > gtg_pkg::PI_Q13) begin
      err = err - gtg_pkg::TWO_PI_Q13;
    end else if (err < -gtg_pkg::PI_Q13) begin
      err = err + gtg_pkg::TWO_PI_Q13;
    end
    turn_nxt = err[gtg_pkg::TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      prod_r <= prod_nxt;
      bear_r <= bear_nxt;
      head_r <= in_data.heading;
    end
    if (rdy2 && v1_r) begin
      speed_r <= speed_nxt;
      turn_r  <= turn_nxt;
    end
  end

  assign out_valid = v2_r;
  assign speed     = speed_r;
  assign turn      = turn_r;

endmodule

>>> hdl/go_to_goal_steering.sv
// top level of the go-to-goal steering block: goal registers, offset stage, cordic row, output
//
// Turns a pose beat (x, y, heading) into a drive beat toward the configured goal point:
// forward_speed is the distance to the goal (unsigned Q7.10, gain compensated, saturated)
// and turn_rate is the bearing to the goal minus the heading, wrapped into [-pi, pi]
// (signed Q3.13 rad). The offset to the goal is scaled up by 8 guard bits, folded into
// the right half plane, and then walks down a row of CORDIC_STEPS (at most 24) vectoring
// cells, one iteration per cell, before a two-stage tail does the 1/K multiply and the
// wrap. The block takes one pose beat every cycle unless out_tready stalls it; a beat
// passes the offset stage, one register per cell, the multiply stage and the output
// register. Each stage holds its own beat and stalls only when the stage after it is
// full, so the pipeline keeps filling while a finished beat waits on out_tready. A pose
// exactly on the goal yields speed 0 and a bearing of 0. The goal registers come up at
// 10.0, 10.0 and are written through the cfg port (index 0 goal_x, 1 goal_y, other
// indexes ignored), which is always ready; write it only while no pose beat is in flight.
module go_to_goal_steering #(
  parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pose beat
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [47:0]                     in_tdata,   // pose_x, pose_y, pose_heading
  // drive beat
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [39:0]                     out_tdata,  // forward_speed, turn_rate, zero pad
  // goal register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gtg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data
);

  `include "go_to_goal_steering_defines.svh"

  // iterations past the arctangent table are dropped
  localparam int STEPS = (CORDIC_STEPS > gtg_pkg::MAX_STEPS) ? gtg_pkg::MAX_STEPS
                                                             : CORDIC_STEPS;

  // goal registers
  logic signed [15:0] goal_x_r;
  logic signed [15:0] goal_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r <= gtg_pkg::GOAL_X_RST;
      goal_y_r <= gtg_pkg::GOAL_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gtg_pkg::REG_GOAL_X: goal_x_r <= cfg_data;
        gtg_pkg::REG_GOAL_Y: goal_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // offset stage: goal minus pose, fold into the right half plane
  logic signed [15:0]             pose_x;
  logic signed [15:0]             pose_y;
  logic signed [15:0]             pose_heading;
  logic signed [gtg_pkg::DW-1:0]  dx;
  logic signed [gtg_pkg::DW-1:0]  dy;
  logic signed [gtg_pkg::DW-1:0]  fx;
  logic signed [gtg_pkg::DW-1:0]  fy;
  gtg_pkg::cord_t                 prep_nxt;
  gtg_pkg::cord_t                 prep_r;
  logic                           prep_valid_r;

  // ready seen by the producer of each row stage
  gtg_pkg::cord_t                 row_data  [0:STEPS];
  logic                           row_valid [0:STEPS];
  logic                           row_ready [0:STEPS];

  assign pose_x       = in_tdata[15:0];
  assign pose_y       = in_tdata[31:16];
  assign pose_heading = in_tdata[47:32];

  always_comb begin
    dx = gtg_pkg::DW'(goal_x_r) - gtg_pkg::DW'(pose_x);
    dy = gtg_pkg::DW'(goal_y_r) - gtg_pkg::DW'(pose_y);
    fx = dx[gtg_pkg::DW-1] ? -dx : dx;
    fy = dx[gtg_pkg::DW-1] ? -dy : dy;
    prep_nxt.zero    = (dx == '0) && (dy == '0);
    prep_nxt.x       = gtg_pkg::XW'(fx) <<< gtg_pkg::GUARD;
    prep_nxt.y       = gtg_pkg::XW'(fy) <<< gtg_pkg::GUARD;
    prep_nxt.heading = pose_heading;
    // a folded vector starts half a turn away
    if (!dx[gtg_pkg::DW-1]) begin
      prep_nxt.z = '0;
    end else if (!dy[gtg_pkg::DW-1]) begin
      prep_nxt.z = gtg_pkg::PI_Z;
    end else begin
      prep_nxt.z = -gtg_pkg::PI_Z;
    end
  end

  assign in_tready = !prep_valid_r || row_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (in_tready) begin
      prep_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      prep_r <= prep_nxt;
    end
  end

  assign row_data[0]  = prep_r;
  assign row_valid[0] = prep_valid_r;

  // cordic row, cell i shifts by i
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    gtg_cordic_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (row_valid[i]),
      .in_ready  (row_ready[i]),
      .in_data   (row_data[i]),
      .out_valid (row_valid[i+1]),
      .out_ready (row_ready[i+1]),
      .out_data  (row_data[i+1])
    );
  end

  // gain compensation, bearing and wrap
  logic [gtg_pkg::SW-1:0]         speed;
  logic signed [gtg_pkg::TW-1:0]  turn;

  gtg_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (row_valid[STEPS]),
    .in_ready  (row_ready[STEPS]),
    .in_data   (row_data[STEPS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .speed     (speed),
    .turn      (turn)
  );

  assign out_tdata = {7'b0, turn, speed};

  // output register empty means every stage can move
  `GTG_ASSERT(a_empty_out_ready, !out_tvalid |-> in_tready, "input stalled with output empty")
  // input stalls only behind a stalled output beat
  `GTG_ASSERT(a_stall_cause, !in_tready |-> (out_tvalid && !out_tready), "stall without back-pressure")
  // wrapped turn rate stays within half a turn
  `GTG_ASSERT(a_turn_range, out_tvalid |-> (turn <= gtg_pkg::TW'(gtg_pkg::PI_Q13) && turn >= -gtg_pkg::TW'(gtg_pkg::PI_Q13)), "turn rate out of range")
  // reset empties the output register
  `GTG_ASSERT_RST(a_rst_clears, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule
